FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Checks that a condition at one edge implies another at the next edge.
`define ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_NEXT(name, clk, rst, cond, expr)
`endif
`endif

FILE: rtl/core/lbs_pkg.sv
// Types and constants for the lexeme boundary scanner.
package lbs_pkg;

   typedef enum logic [7:0] {
      MODE_BOUNDARY = 8'b0000_0001,
      MODE_SPACE    = 8'b0000_0010,
      MODE_QUOTE    = 8'b0000_0100,
      MODE_COMMA    = 8'b0000_1000,
      MODE_OPERAND  = 8'b0001_0000,
      MODE_OPERATOR = 8'b0010_0000,
      MODE_LINE     = 8'b0100_0000,
      MODE_BLOCK    = 8'b1000_0000
   } mode_type;

   typedef enum logic [2:0] {
      KIND_SPACE    = 3'd0,
      KIND_QUOTE    = 3'd1,
      KIND_COMMA    = 3'd2,
      KIND_OPERAND  = 3'd3,
      KIND_OPERATOR = 3'd4,
      KIND_SINGLE   = 3'd5,
      KIND_COMMENT  = 3'd6
   } kind_type;

   typedef struct packed {
      mode_type mode;
      logic     quote_dbl;
      logic     esc_pending;
      logic     star_seen;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      mode: MODE_BOUNDARY, quote_dbl: 1'b0, esc_pending: 1'b0, star_seen: 1'b0
   };

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LBRC  = 8'h7B;
   localparam logic [7:0] CH_RBRC  = 8'h7D;

endpackage

FILE: rtl/core/lexeme_boundary_scanner_unit.sv
// Lexeme boundary scanner: tags each source byte with its lexeme kind and a start flag.
//
// Takes one byte word per cycle, unless stalled, and returns each byte tagged one input
// later, since a slash needs the following byte to tell a comment opener from an
// operator. The first byte of a text gives no result; an end-of-text word flushes the
// held byte (or gives an empty last result) and returns the scanner to its fresh state.
// Throughput is one word per clock while req_stall is low: the held byte and the scan
// state form a single register stage, the classifier is one level of combinational
// logic, and the result sits in an output register. A result appears on rsp_valid the
// cycle after the word that caused it is accepted. req_stall is raised only while the
// output register holds a result that the consumer stalls.
`include "assert_macros.svh"

module lexeme_boundary_scanner_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_has_byte,
   output logic [2:0] rsp_lexeme_kind,
   output logic       rsp_lexeme_start,
   output logic       rsp_is_last
);
   import lbs_pkg::*;

   logic [7:0]     held_byte_ff, held_byte_in;
   logic           held_valid_ff, held_valid_in;
   scan_state_type scan_ff, scan_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic           has_byte_ff, has_byte_in;
   kind_type       kind_ff, kind_in;
   logic           start_ff, start_in;
   logic           last_ff, last_in;

   scan_state_type cls_next;
   kind_type       cls_kind;
   logic           cls_start;
   logic           accept;
   logic           produce;

   lbs_classify u_classify (
      .cur_byte (held_byte_ff),
      .nxt_ok   (!req_end_of_text),
      .nxt_byte (req_text_byte),
      .st       (scan_ff),
      .st_next  (cls_next),
      .kind     (cls_kind),
      .start    (cls_start)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   // Every word yields a result except the first byte of a text.
   assign produce   = accept && (req_end_of_text || held_valid_ff);

   always_comb begin
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      scan_in       = scan_ff;
      byte_in       = byte_ff;
      has_byte_in   = has_byte_ff;
      kind_in       = kind_ff;
      start_in      = start_ff;
      last_in       = last_ff;
      rsp_valid_in  = produce || (rsp_valid_ff && rsp_stall);

      if (accept) begin
         if (req_end_of_text) begin
            byte_in       = held_valid_ff ? held_byte_ff : CH_NUL;
            has_byte_in   = held_valid_ff;
            kind_in       = held_valid_ff ? cls_kind : KIND_SPACE;
            start_in      = held_valid_ff && cls_start;
            last_in       = 1'b1;
            held_byte_in  = CH_NUL;
            held_valid_in = 1'b0;
            scan_in       = SCAN_RESET;
         end else if (!held_valid_ff) begin
            held_byte_in  = req_text_byte;
            held_valid_in = 1'b1;
         end else begin
            byte_in      = held_byte_ff;
            has_byte_in  = 1'b1;
            kind_in      = cls_kind;
            start_in     = cls_start;
            last_in      = 1'b0;
            held_byte_in = req_text_byte;
            scan_in      = cls_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         scan_ff       <= SCAN_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         scan_ff       <= scan_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      byte_ff      <= byte_in;
      has_byte_ff  <= has_byte_in;
      kind_ff      <= kind_in;
      start_ff     <= start_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = byte_ff;
   assign rsp_has_byte     = has_byte_ff;
   assign rsp_lexeme_kind  = kind_ff;
   assign rsp_lexeme_start = start_ff;
   assign rsp_is_last      = last_ff;

   `ASSERT_ALWAYS(a_mode_onehot, clock, reset, $onehot(scan_ff.mode))
   `ASSERT_ALWAYS(a_empty_is_last, clock, reset,
      !(rsp_valid_ff && !has_byte_ff) || (last_ff && !start_ff && kind_ff == KIND_SPACE))
   `ASSERT_NEXT(a_eot_clears, clock, reset, accept && req_end_of_text,
      !held_valid_ff && scan_ff.mode == MODE_BOUNDARY)
   `ASSERT_NEXT(a_byte_held, clock, reset, accept && !req_end_of_text,
      held_valid_ff && rsp_valid_ff == $past(held_valid_ff || (rsp_valid_ff && rsp_stall)))

endmodule

FILE: rtl/core/lbs_classify.sv
// Classifies one held byte against the open lexeme and computes the next scan state.
module lbs_classify (
   input  logic [7:0]            cur_byte,
   input  logic                  nxt_ok,
   input  logic [7:0]            nxt_byte,
   input  lbs_pkg::scan_state_type st,
   output lbs_pkg::scan_state_type st_next,
   output lbs_pkg::kind_type     kind,
   output logic                  start
);
   import lbs_pkg::*;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
   endfunction

   function automatic logic is_quote(input logic [7:0] b);
      return (b == CH_DQUOTE) || (b == CH_APOS);
   endfunction

   function automatic logic is_delim(input logic [7:0] b);
      return (b == CH_NUL) || is_space(b) || (b == CH_LF) || (b == CH_SEMI) ||
             (b == CH_LPAR) || (b == CH_RPAR) || (b == CH_LBRK) || (b == CH_RBRK) ||
             (b == CH_LBRC) || (b == CH_RBRC);
   endfunction

   function automatic logic is_operand(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
             (b >= 8'h41 && b <= 8'h5A) || (b == CH_APOS) || (b == CH_UNDER);
   endfunction

   function automatic logic is_operator(input logic [7:0] b);
      return (b != CH_NUL) && !b[7] && !is_delim(b) && !is_operand(b) && !is_quote(b);
   endfunction

   always_comb begin
      scan_state_type ns;
      logic           cont;
      logic [7:0]     close_ch;
      ns       = st;
      cont     = 1'b0;
      kind     = KIND_SINGLE;
      close_ch = st.quote_dbl ? CH_DQUOTE : CH_APOS;

      unique case (st.mode)
         MODE_SPACE: begin
            cont = is_space(cur_byte);
            kind = KIND_SPACE;
         end
         MODE_COMMA: begin
            cont = (cur_byte == CH_COMMA);
            kind = KIND_COMMA;
         end
         MODE_OPERAND: begin
            cont = is_operand(cur_byte);
            kind = KIND_OPERAND;
         end
         MODE_OPERATOR: begin
            cont = is_operator(cur_byte);
            kind = KIND_OPERATOR;
         end
         MODE_QUOTE: begin
            kind = KIND_QUOTE;
            if (cur_byte == CH_NUL) begin
               ns.esc_pending = 1'b0;
            end else if (st.esc_pending) begin
               ns.esc_pending = 1'b0;
               cont = 1'b1;
            end else if (cur_byte == CH_LF) begin
               cont = 1'b0;
            end else if (cur_byte == CH_BSLASH) begin
               ns.esc_pending = 1'b1;
               cont = 1'b1;
            end else begin
               if (cur_byte == close_ch) ns.mode = MODE_BOUNDARY;
               cont = 1'b1;
            end
         end
         MODE_LINE: begin
            cont = (cur_byte != CH_LF) && (cur_byte != CH_NUL);
            kind = KIND_COMMENT;
         end
         MODE_BLOCK: begin
            kind = KIND_COMMENT;
            if (cur_byte == CH_NUL) begin
               ns.star_seen = 1'b0;
            end else begin
               // The opening star counts, so a slash right after it closes the comment.
               if (st.star_seen && cur_byte == CH_SLASH) ns.mode = MODE_BOUNDARY;
               ns.star_seen = (cur_byte == CH_STAR);
               cont = 1'b1;
            end
         end
         default: cont = 1'b0;
      endcase

      start = !cont;
      if (!cont) begin
         if (cur_byte == CH_SLASH && nxt_ok &&
             (nxt_byte == CH_SLASH || nxt_byte == CH_STAR)) begin
            ns.mode      = (nxt_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            ns.star_seen = 1'b0;
            kind         = KIND_COMMENT;
         end else if (is_space(cur_byte)) begin
            ns.mode = MODE_SPACE;
            kind    = KIND_SPACE;
         end else if (is_quote(cur_byte)) begin
            ns.mode        = MODE_QUOTE;
            ns.quote_dbl   = (cur_byte == CH_DQUOTE);
            ns.esc_pending = 1'b0;
            kind           = KIND_QUOTE;
         end else if (cur_byte == CH_COMMA) begin
            ns.mode = MODE_COMMA;
            kind    = KIND_COMMA;
         end else if (is_operand(cur_byte)) begin
            ns.mode = MODE_OPERAND;
            kind    = KIND_OPERAND;
         end else if (is_operator(cur_byte)) begin
            ns.mode = MODE_OPERATOR;
            kind    = KIND_OPERATOR;
         end else begin
            ns.mode = MODE_BOUNDARY;
            kind    = KIND_SINGLE;
         end
      end
      st_next = ns;
   end

endmodule

FILE: verif/lexeme_boundary_scanner_unit_tb.sv
// Self-checking testbench for the lexeme boundary scanner: directed texts, random texts, stalls.
module lexeme_boundary_scanner_unit_tb;
   import lbs_pkg::*;

   // The longest quiet stretch in a correct run is the long output hold below; the
   // limit is several times that.
   localparam int unsigned LONG_HOLD   = 250;
   localparam int unsigned STUCK_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] data;
      logic       has_data;
      kind_type   kind;
      logic       starts;
      logic       last;
   } tag_word_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_text_byte;
   logic       req_end_of_text;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_byte_out;
   logic       rsp_has_byte;
   logic [2:0] rsp_lexeme_kind;
   logic       rsp_lexeme_start;
   logic       rsp_is_last;

   // Scanner state as predicted from the accepted words.
   logic [7:0] pending_byte;
   logic       pending_ok;
   mode_type   lex_mode;
   logic       quote_dbl;
   logic       esc_open;
   logic       star_open;

   tag_word_type pending_tags[$];

   int unsigned words_sent;
   int unsigned texts_sent;
   int unsigned tags_checked;
   int unsigned mismatches;
   int unsigned stall_cycles;
   int unsigned holds_asked;
   int unsigned holds_served;
   int unsigned stuck_cycles = 0;
   logic        source_idle_on;
   logic        sink_idle_on;

   string OPERAND_SET  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_'";
   string OPERATOR_SET = "!#$%&*+-./:<=>?@\\^`|~,";
   string DELIM_SET    = ";()[]{}\n";

   lexeme_boundary_scanner_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_lexeme_kind (rsp_lexeme_kind),
      .rsp_lexeme_start(rsp_lexeme_start),
      .rsp_is_last     (rsp_is_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic is_space(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR;
   endfunction

   function automatic logic is_quote(input logic [7:0] b);
      return b == CH_DQUOTE || b == CH_APOS;
   endfunction

   function automatic logic is_delim(input logic [7:0] b);
      return b == CH_NUL || is_space(b) || b == CH_LF || b == CH_SEMI ||
             b == CH_LPAR || b == CH_RPAR || b == CH_LBRK || b == CH_RBRK ||
             b == CH_LBRC || b == CH_RBRC;
   endfunction

   function automatic logic is_operand(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
             (b >= "A" && b <= "Z") || b == CH_APOS || b == CH_UNDER;
   endfunction

   function automatic logic is_operator(input logic [7:0] b);
      return b != CH_NUL && b < 8'h80 && !is_delim(b) && !is_operand(b) && !is_quote(b);
   endfunction

   // Opens a lexeme on byte b; a slash needs the following byte to become a comment.
   function automatic kind_type open_lexeme(input logic [7:0] b, input logic look_ok,
                                            input logic [7:0] look);
      if (b == CH_SLASH && look_ok && (look == CH_SLASH || look == CH_STAR)) begin
         lex_mode  = (look == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
         star_open = 1'b0;
         return KIND_COMMENT;
      end
      if (is_space(b)) begin
         lex_mode = MODE_SPACE;
         return KIND_SPACE;
      end
      if (is_quote(b)) begin
         lex_mode  = MODE_QUOTE;
         quote_dbl = (b == CH_DQUOTE);
         esc_open  = 1'b0;
         return KIND_QUOTE;
      end
      if (b == CH_COMMA) begin
         lex_mode = MODE_COMMA;
         return KIND_COMMA;
      end
      if (is_operand(b)) begin
         lex_mode = MODE_OPERAND;
         return KIND_OPERAND;
      end
      if (is_operator(b)) begin
         lex_mode = MODE_OPERATOR;
         return KIND_OPERATOR;
      end
      lex_mode = MODE_BOUNDARY;
      return KIND_SINGLE;
   endfunction

   function automatic kind_type tag_byte(input logic [7:0] b, input logic look_ok,
                                         input logic [7:0] look, output logic begins);
      begins = 1'b0;
      case (lex_mode)
         MODE_SPACE: if (is_space(b)) return KIND_SPACE;
         MODE_COMMA: if (b == CH_COMMA) return KIND_COMMA;
         MODE_OPERAND: if (is_operand(b)) return KIND_OPERAND;
         MODE_OPERATOR: if (is_operator(b)) return KIND_OPERATOR;
         MODE_QUOTE: begin
            if (b == CH_NUL) begin
               esc_open = 1'b0;
            end else if (esc_open) begin
               esc_open = 1'b0;
               return KIND_QUOTE;
            end else if (b != CH_LF) begin
               if (b == CH_BSLASH)
                  esc_open = 1'b1;
               else if (b == (quote_dbl ? CH_DQUOTE : CH_APOS))
                  lex_mode = MODE_BOUNDARY;
               return KIND_QUOTE;
            end
         end
         MODE_LINE: if (b != CH_LF && b != CH_NUL) return KIND_COMMENT;
         MODE_BLOCK: begin
            if (b == CH_NUL) begin
               star_open = 1'b0;
            end else begin
               if (star_open && b == CH_SLASH) lex_mode = MODE_BOUNDARY;
               star_open = (b == CH_STAR);
               return KIND_COMMENT;
            end
         end
         default: ;
      endcase
      begins = 1'b1;
      return open_lexeme(b, look_ok, look);
   endfunction

   function automatic void clear_scan();
      pending_byte = 8'h00;
      pending_ok   = 1'b0;
      lex_mode     = MODE_BOUNDARY;
      quote_dbl    = 1'b0;
      esc_open     = 1'b0;
      star_open    = 1'b0;
   endfunction

   // Advances the predicted scanner by one accepted word and queues the tag it yields.
   function automatic void scan_word(input logic [7:0] b, input logic eot);
      tag_word_type t;
      logic         begins;
      t = '0;
      if (eot) begin
         if (pending_ok) begin
            t.kind     = tag_byte(pending_byte, 1'b0, 8'h00, begins);
            t.data     = pending_byte;
            t.has_data = 1'b1;
            t.starts   = begins;
         end else begin
            t.kind = KIND_SPACE;
         end
         t.last = 1'b1;
         pending_tags.push_back(t);
         clear_scan();
      end else if (!pending_ok) begin
         pending_byte = b;
         pending_ok   = 1'b1;
      end else begin
         t.kind     = tag_byte(pending_byte, 1'b1, b, begins);
         t.data     = pending_byte;
         t.has_data = 1'b1;
         t.starts   = begins;
         pending_tags.push_back(t);
         pending_byte = b;
      end
   endfunction

   task automatic send_word(input logic [7:0] b, input logic eot);
      @(negedge clock);
      if (source_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid     = 1'b0;
         req_text_byte = 8'($urandom_range(0, 255));
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_text_byte   = b;
      req_end_of_text = eot;
      do @(posedge clock); while (req_stall);
      scan_word(b, eot);
      words_sent++;
      if (eot) texts_sent++;
   endtask

   function automatic logic [7:0] pick_char(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // Sends one piece of source text: mostly well-formed lexemes, some noise.
   task automatic emit_fragment();
      logic [7:0] q;
      case ($urandom_range(0, 11))
         0, 1: repeat ($urandom_range(1, 6)) send_word(pick_char(OPERAND_SET), 1'b0);
         2: repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
               0: send_word(CH_SPACE, 1'b0);
               1: send_word(CH_TAB, 1'b0);
               default: send_word(CH_CR, 1'b0);
            endcase
         end
         3: begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_APOS;
            send_word(q, 1'b0);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 7))
                  0: begin
                     send_word(CH_BSLASH, 1'b0);
                     case ($urandom_range(0, 3))
                        0: send_word(CH_LF, 1'b0);
                        1: send_word(q, 1'b0);
                        2: send_word(CH_BSLASH, 1'b0);
                        default: send_word(8'($urandom_range(0, 255)), 1'b0);
                     endcase
                  end
                  1: send_word(q ^ CH_DQUOTE ^ CH_APOS, 1'b0);
                  2: send_word(8'($urandom_range(128, 255)), 1'b0);
                  default: send_word(8'($urandom_range(32, 126)), 1'b0);
               endcase
            end
            case ($urandom_range(0, 5))
               0: send_word(CH_LF, 1'b0);
               1: ;
               default: send_word(q, 1'b0);
            endcase
         end
         4: begin
            send_word(CH_SLASH, 1'b0);
            send_word(CH_SLASH, 1'b0);
            repeat ($urandom_range(0, 6)) send_word(8'($urandom_range(1, 255)), 1'b0);
            send_word(CH_LF, 1'b0);
         end
         5: begin
            send_word(CH_SLASH, 1'b0);
            send_word(CH_STAR, 1'b0);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 3))
                  0: send_word(CH_STAR, 1'b0);
                  1: send_word(CH_SLASH, 1'b0);
                  default: send_word(8'($urandom_range(1, 255)), 1'b0);
               endcase
            end
            if ($urandom_range(0, 4) != 0) begin
               send_word(CH_STAR, 1'b0);
               send_word(CH_SLASH, 1'b0);
            end
         end
         6: repeat ($urandom_range(1, 3)) send_word(pick_char(OPERATOR_SET), 1'b0);
         7: repeat ($urandom_range(1, 3)) send_word(CH_COMMA, 1'b0);
         8: send_word(pick_char(DELIM_SET), 1'b0);
         9: repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)), 1'b0);
         10: send_word(8'($urandom_range(128, 255)), 1'b0);
         default: send_word(CH_NUL, 1'b0);
      endcase
   endtask

   task automatic test_empty_text();
      send_word(8'hA5, 1'b1);
   endtask

   // A block comment closed by the star that opened it, a line comment up to the
   // newline, and a slash with no byte after it.
   task automatic test_comments();
      send_word(CH_SLASH, 1'b0);
      send_word(CH_STAR, 1'b0);
      send_word(CH_SLASH, 1'b0);
      send_word(CH_SLASH, 1'b0);
      send_word(CH_SLASH, 1'b0);
      send_word("x", 1'b0);
      send_word(CH_LF, 1'b0);
      send_word(CH_SLASH, 1'b0);
      send_word(8'h00, 1'b1);
   endtask

   // Escaped newline, zero byte after a backslash, high byte inside a quote, and an
   // unescaped newline that ends the quote.
   task automatic test_quotes();
      send_word(CH_DQUOTE, 1'b0);
      send_word(CH_BSLASH, 1'b0);
      send_word(CH_LF, 1'b0);
      send_word(CH_BSLASH, 1'b0);
      send_word(CH_NUL, 1'b0);
      send_word(CH_APOS, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(CH_LF, 1'b0);
      send_word(8'hFF, 1'b1);
   endtask

   // Apostrophe inside an operand, commas continuing an operator run, a high byte
   // ending a run, and a pure comma run.
   task automatic test_runs();
      send_word("a", 1'b0);
      send_word(CH_APOS, 1'b0);
      send_word(CH_UNDER, 1'b0);
      send_word(CH_TAB, 1'b0);
      send_word("+", 1'b0);
      send_word(CH_COMMA, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(CH_COMMA, 1'b0);
      send_word(CH_COMMA, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(CH_SEMI, 1'b0);
      send_word(8'h5A, 1'b1);
   endtask

   task automatic test_random_text(input int unsigned n_words);
      int unsigned stop_at;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         repeat ($urandom_range(0, 8)) emit_fragment();
         send_word(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // The consumer holds off for a long stretch while words keep coming, so the
   // scanner fills up and stalls its input.
   task automatic test_backpressure();
      holds_asked++;
      test_random_text(40);
   endtask

   initial begin : sink_stall
      int unsigned burst;
      burst     = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            burst = LONG_HOLD;
         end else if (burst == 0 && sink_idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 19);
         end
         rsp_stall = (burst != 0);
         if (burst != 0) burst--;
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_tags
      tag_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tags.size() == 0) begin
            $error("unexpected result word: byte %0d, is_last %0d", rsp_byte_out, rsp_is_last);
            mismatches++;
         end else begin
            want = pending_tags.pop_front();
            check_field("byte_out", want.data, rsp_byte_out);
            check_field("has_byte", want.has_data, rsp_has_byte);
            check_field("lexeme_kind", want.kind, rsp_lexeme_kind);
            check_field("lexeme_start", want.starts, rsp_lexeme_start);
            check_field("is_last", want.last, rsp_is_last);
            tags_checked++;
         end
      end
      if (!reset && rsp_stall) stall_cycles++;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("lexeme_boundary_scanner_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = 8'h00;
      req_end_of_text = 1'b0;
      source_idle_on  = 1'b0;
      sink_idle_on    = 1'b0;
      words_sent      = 0;
      texts_sent      = 0;
      tags_checked    = 0;
      mismatches      = 0;
      stall_cycles    = 0;
      holds_asked     = 0;
      holds_served    = 0;
      clear_scan();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_text();
      test_comments();
      test_quotes();
      test_runs();

      source_idle_on = 1'b1;
      sink_idle_on   = 1'b1;
      test_random_text(900);
      source_idle_on = 1'b0;
      test_backpressure();
      source_idle_on = 1'b1;
      test_random_text(550);
      source_idle_on = 1'b0;
      sink_idle_on   = 1'b0;
      test_random_text(300);

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Scanned %0d words in %0d texts and checked %0d tagged words.",
               words_sent, texts_sent, tags_checked);
      $display("Covered comments, quotes with escapes, every run kind, and %0d stalled cycles.",
               stall_cycles);
      if (mismatches == 0 && pending_tags.size() == 0)
         $display("lexeme_boundary_scanner_unit: match");
      else
         $display("lexeme_boundary_scanner_unit: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/lbs_pkg.sv
rtl/core/lbs_classify.sv
rtl/core/lexeme_boundary_scanner_unit.sv
verif/lexeme_boundary_scanner_unit_tb.sv
